/* design/sbe_pkg.sv */
`default_nettype none

package sbe_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int LOCAL_COUNT = 16;

  localparam int CntW    = $clog2(STACK_DEPTH + 1);
  localparam int LocIdxW = $clog2(LOCAL_COUNT);

  localparam logic [4:0] SHIFT_MASK = 5'h1f;

  // opcodes
  localparam logic [7:0] OP_NOP           = 8'h00;
  localparam logic [7:0] OP_ICONST_M1     = 8'h02;
  localparam logic [7:0] OP_ICONST_0      = 8'h03;
  localparam logic [7:0] OP_ICONST_1      = 8'h04;
  localparam logic [7:0] OP_ICONST_2      = 8'h05;
  localparam logic [7:0] OP_ICONST_3      = 8'h06;
  localparam logic [7:0] OP_ICONST_4      = 8'h07;
  localparam logic [7:0] OP_ICONST_5      = 8'h08;
  localparam logic [7:0] OP_BIPUSH        = 8'h10;
  localparam logic [7:0] OP_ILOAD_0       = 8'h1a;
  localparam logic [7:0] OP_ILOAD_1       = 8'h1b;
  localparam logic [7:0] OP_ILOAD_2       = 8'h1c;
  localparam logic [7:0] OP_ALOAD_0       = 8'h2a;
  localparam logic [7:0] OP_ISTORE_0      = 8'h3b;
  localparam logic [7:0] OP_ISTORE_1      = 8'h3c;
  localparam logic [7:0] OP_ISTORE_2      = 8'h3d;
  localparam logic [7:0] OP_ISHL          = 8'h78;
  localparam logic [7:0] OP_IINC          = 8'h84;
  localparam logic [7:0] OP_IFLT          = 8'h9b;
  localparam logic [7:0] OP_IF_ICMPGE     = 8'ha2;
  localparam logic [7:0] OP_GOTO          = 8'ha7;
  localparam logic [7:0] OP_RETURN        = 8'hb1;
  localparam logic [7:0] OP_INVOKESPECIAL = 8'hb7;
  localparam logic [7:0] OP_INVOKESTATIC  = 8'hb8;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_LOCAL = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    STK_NONE,
    STK_PUSH,
    STK_POP,
    STK_POP2,
    STK_POP2_PUSH
  } stk_op_e;

  typedef struct packed {
    stk_op_e     op;
    logic [31:0] data;
  } stk_ctl_t;

  typedef struct packed {
    logic               en;
    logic [LocIdxW-1:0] idx;
    logic [31:0]        data;
  } loc_wr_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        led_valid;
    logic [7:0]  led_value;
    logic        halted;
    err_e        error;
  } result_t;

  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

endpackage

`default_nettype wire

/* design/stack_bytecode_executor.sv */
`default_nettype none

// Executes one instruction of a small JVM bytecode subset per request: the opcode
// and the two code bytes after it go in, the new program counter, LED write,
// halt flag and error code come out. Every instruction is handled by the single
// combinational execute stage, so a new request is taken each clock while the
// output is not stalled; the request is held in the input register and the
// result in the result register, with the execute stage between them. The operand
// stack is a shift register (top at entry 0) and locals are a small flip-flop
// file, so the stack and locals updates from one instruction are visible to the
// very next one. Once RETURN executes, later requests are answered with halted
// set and change nothing until reset.
module stack_bytecode_executor
  import sbe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  op_i,
  input  wire logic [7:0]  first_byte_i,
  input  wire logic [7:0]  second_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      next_pc_o,
  output logic             led_valid_o,
  output logic [7:0]       led_value_o,
  output logic             halted_o,
  output logic [1:0]       error_o
);

  logic               in_vld_q, in_vld_d;
  logic [7:0]         op_q, b1_q, b2_q;
  logic               out_vld_q, out_vld_d;
  result_t            res_q;
  logic [15:0]        pc_q;
  logic               halt_q;
  logic               accept_in, exec_fire;

  logic [CntW-1:0]    stk_count;
  logic [31:0]        tos, nos, loc_rd;
  logic [LocIdxW-1:0] loc_rd_idx;
  loc_wr_t            loc_wr;
  stk_ctl_t           stk_ctl;
  result_t            res;

  assign exec_fire  = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !exec_fire;
  assign accept_in  = in_valid_i && !in_stall_o;

  assign in_vld_d  = accept_in || (in_vld_q && !exec_fire);
  assign out_vld_d = exec_fire || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pc_q      <= '0;
      halt_q    <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (exec_fire) begin
        pc_q   <= res.next_pc;
        halt_q <= res.halted;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      op_q <= op_i;
      b1_q <= first_byte_i;
      b2_q <= second_byte_i;
    end
    if (exec_fire) begin
      res_q <= res;
    end
  end

  sbe_exec u_exec (
    .op_i          (op_q),
    .first_byte_i  (b1_q),
    .second_byte_i (b2_q),
    .pc_i          (pc_q),
    .halt_i        (halt_q),
    .count_i       (stk_count),
    .tos_i         (tos),
    .nos_i         (nos),
    .loc_rd_i      (loc_rd),
    .loc_rd_idx_o  (loc_rd_idx),
    .loc_wr_o      (loc_wr),
    .stk_o         (stk_ctl),
    .res_o         (res)
  );

  sbe_stack u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (exec_fire),
    .ctl_i   (stk_ctl),
    .count_o (stk_count),
    .tos_o   (tos),
    .nos_o   (nos)
  );

  sbe_locals u_locals (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (exec_fire),
    .wr_i      (loc_wr),
    .rd_idx_i  (loc_rd_idx),
    .rd_data_o (loc_rd)
  );

  assign out_valid_o = out_vld_q;
  assign next_pc_o   = res_q.next_pc;
  assign led_valid_o = res_q.led_valid;
  assign led_value_o = res_q.led_value;
  assign halted_o    = res_q.halted;
  assign error_o     = res_q.error;

endmodule

`default_nettype wire

/* design/sbe_stack.sv */
`default_nettype none

module sbe_stack
  import sbe_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire stk_ctl_t        ctl_i,
  output logic [CntW-1:0]      count_o,
  output logic [31:0]          tos_o,
  output logic [31:0]          nos_o
);

  logic [31:0]     ent_q [STACK_DEPTH];
  logic [31:0]     ent_d [STACK_DEPTH];
  logic [31:0]     up1   [STACK_DEPTH];
  logic [31:0]     up2   [STACK_DEPTH];
  logic [31:0]     dn1   [STACK_DEPTH];
  logic [CntW-1:0] cnt_q, cnt_d;

  // shifted views of the stack; entry 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_shift
    if (i < STACK_DEPTH - 1) begin : g_up1
      assign up1[i] = ent_q[i+1];
    end else begin : g_up1_end
      assign up1[i] = ent_q[i];
    end
    if (i < STACK_DEPTH - 2) begin : g_up2
      assign up2[i] = ent_q[i+2];
    end else begin : g_up2_end
      assign up2[i] = ent_q[i];
    end
    if (i > 0) begin : g_dn1
      assign dn1[i] = ent_q[i-1];
    end else begin : g_dn1_top
      assign dn1[i] = ctl_i.data;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      ent_d[i] = ent_q[i];
    end
    if (en_i) begin
      unique case (ctl_i.op)
        STK_PUSH: begin
          for (int i = 0; i < STACK_DEPTH; i++) ent_d[i] = dn1[i];
          cnt_d = cnt_q + CntW'(1);
        end
        STK_POP: begin
          for (int i = 0; i < STACK_DEPTH; i++) ent_d[i] = up1[i];
          cnt_d = cnt_q - CntW'(1);
        end
        STK_POP2: begin
          for (int i = 0; i < STACK_DEPTH; i++) ent_d[i] = up2[i];
          cnt_d = cnt_q - CntW'(2);
        end
        STK_POP2_PUSH: begin
          for (int i = 1; i < STACK_DEPTH; i++) ent_d[i] = up1[i];
          ent_d[0] = ctl_i.data;
          cnt_d = cnt_q - CntW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign count_o = cnt_q;
  assign tos_o   = ent_q[0];
  assign nos_o   = ent_q[1];

endmodule

`default_nettype wire

/* design/sbe_locals.sv */
`default_nettype none

module sbe_locals
  import sbe_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire loc_wr_t            wr_i,
  input  wire logic [LocIdxW-1:0] rd_idx_i,
  output logic [31:0]             rd_data_o
);

  logic [31:0] loc_q [LOCAL_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LOCAL_COUNT; i++) loc_q[i] <= '0;
    end else if (en_i && wr_i.en) begin
      loc_q[wr_i.idx] <= wr_i.data;
    end
  end

  assign rd_data_o = loc_q[rd_idx_i];

endmodule

`default_nettype wire

/* design/sbe_exec.sv */
`default_nettype none

module sbe_exec
  import sbe_pkg::*;
(
  input  wire logic [7:0]         op_i,
  input  wire logic [7:0]         first_byte_i,
  input  wire logic [7:0]         second_byte_i,
  input  wire logic [15:0]        pc_i,
  input  wire logic               halt_i,
  input  wire logic [CntW-1:0]    count_i,
  input  wire logic [31:0]        tos_i,
  input  wire logic [31:0]        nos_i,
  input  wire logic [31:0]        loc_rd_i,
  output logic [LocIdxW-1:0]      loc_rd_idx_o,
  output loc_wr_t                 loc_wr_o,
  output stk_ctl_t                stk_o,
  output result_t                 res_o
);

  logic [15:0] pc_br;
  logic [15:0] pc_p1, pc_p2, pc_p3;
  logic        full, lt1, lt2, bad_loc;
  logic [7:0]  cval;

  assign pc_br   = pc_i + {first_byte_i, second_byte_i};
  assign pc_p1   = pc_i + 16'd1;
  assign pc_p2   = pc_i + 16'd2;
  assign pc_p3   = pc_i + 16'd3;
  assign full    = (count_i == CntW'(STACK_DEPTH));
  assign lt1     = (count_i < CntW'(1));
  assign lt2     = (count_i < CntW'(2));
  assign bad_loc = ({1'b0, first_byte_i} >= 9'(LOCAL_COUNT));
  assign cval    = op_i - OP_ICONST_0;

  always_comb begin
    res_o.next_pc   = pc_p1;
    res_o.led_valid = 1'b0;
    res_o.led_value = '0;
    res_o.halted    = 1'b0;
    res_o.error     = ERR_NONE;
    stk_o.op        = STK_NONE;
    stk_o.data      = '0;
    loc_wr_o.en     = 1'b0;
    loc_wr_o.idx    = '0;
    loc_wr_o.data   = '0;
    loc_rd_idx_o    = '0;

    if (halt_i) begin
      // hold everything while halted
      res_o.next_pc = pc_i;
      res_o.halted  = 1'b1;
    end else begin
      unique case (op_i)
        OP_ICONST_M1, OP_ICONST_0, OP_ICONST_1, OP_ICONST_2,
        OP_ICONST_3, OP_ICONST_4, OP_ICONST_5: begin
          stk_o.data = sext8(cval);
          if (full) res_o.error = ERR_OVER;
          else      stk_o.op    = STK_PUSH;
        end
        OP_BIPUSH: begin
          res_o.next_pc = pc_p2;
          stk_o.data    = sext8(first_byte_i);
          if (full) res_o.error = ERR_OVER;
          else      stk_o.op    = STK_PUSH;
        end
        OP_ILOAD_0, OP_ILOAD_1, OP_ILOAD_2, OP_ALOAD_0: begin
          if (op_i != OP_ALOAD_0) loc_rd_idx_o = LocIdxW'(op_i - OP_ILOAD_0);
          stk_o.data = loc_rd_i;
          if (full) res_o.error = ERR_OVER;
          else      stk_o.op    = STK_PUSH;
        end
        OP_ISTORE_0, OP_ISTORE_1, OP_ISTORE_2: begin
          loc_wr_o.idx  = LocIdxW'(op_i - OP_ISTORE_0);
          loc_wr_o.data = tos_i;
          if (lt1) begin
            res_o.error = ERR_UNDER;
          end else begin
            stk_o.op    = STK_POP;
            loc_wr_o.en = 1'b1;
          end
        end
        OP_ISHL: begin
          stk_o.data = nos_i << (tos_i[4:0] & SHIFT_MASK);
          if (lt2) res_o.error = ERR_UNDER;
          else     stk_o.op    = STK_POP2_PUSH;
        end
        OP_IINC: begin
          res_o.next_pc = pc_p3;
          loc_rd_idx_o  = first_byte_i[LocIdxW-1:0];
          loc_wr_o.idx  = first_byte_i[LocIdxW-1:0];
          loc_wr_o.data = loc_rd_i + sext8(second_byte_i);
          if (bad_loc) res_o.error = ERR_LOCAL;
          else         loc_wr_o.en = 1'b1;
        end
        OP_IFLT: begin
          res_o.next_pc = pc_p3;
          if (lt1) begin
            res_o.error = ERR_UNDER;
          end else begin
            stk_o.op = STK_POP;
            if (tos_i[31]) res_o.next_pc = pc_br;
          end
        end
        OP_IF_ICMPGE: begin
          res_o.next_pc = pc_p3;
          if (lt2) begin
            res_o.error = ERR_UNDER;
          end else begin
            stk_o.op = STK_POP2;
            if ($signed(nos_i) >= $signed(tos_i)) res_o.next_pc = pc_br;
          end
        end
        OP_GOTO: begin
          res_o.next_pc = pc_br;
        end
        OP_RETURN: begin
          res_o.next_pc = pc_i;
          res_o.halted  = 1'b1;
        end
        OP_INVOKESPECIAL: begin
          res_o.next_pc = pc_p3;
        end
        OP_INVOKESTATIC: begin
          res_o.next_pc = pc_p3;
          if (lt1) begin
            res_o.error = ERR_UNDER;
          end else begin
            stk_o.op        = STK_POP;
            res_o.led_valid = 1'b1;
            res_o.led_value = tos_i[7:0];
          end
        end
        default: begin
          // NOP and unknown opcodes just advance
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import sbe_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] op_i = OP_NOP;
  logic [7:0] first_byte_i = 8'h00;
  logic [7:0] second_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [15:0] next_pc_o;
  logic       led_valid_o;
  logic [7:0] led_value_o;
  logic       halted_o;
  logic [1:0] error_o;

  stack_bytecode_executor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .first_byte_i  (first_byte_i),
    .second_byte_i (second_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .next_pc_o     (next_pc_o),
    .led_valid_o   (led_valid_o),
    .led_value_o   (led_value_o),
    .halted_o      (halted_o),
    .error_o       (error_o)
  );

  always #5 clk_i = ~clk_i;

  // Machine state as the predictor sees it.
  logic [15:0] m_pc = 16'h0000;
  logic [31:0] m_stack [STACK_DEPTH];
  int          m_depth = 0;
  logic [31:0] m_locals [LOCAL_COUNT];
  bit          m_halted = 1'b0;

  result_t predicted_results [$];
  int      fail_count = 0;
  int      quiet_cycles = 0;
  bit      in_idle = 1'b1;
  bit      out_idle = 1'b1;
  int      out_wait = 0;

  function automatic bit stack_push(input logic [31:0] word);
    if (m_depth >= STACK_DEPTH) return 1'b0;
    m_stack[m_depth] = word;
    m_depth++;
    return 1'b1;
  endfunction

  function automatic logic [31:0] stack_pop();
    m_depth--;
    return m_stack[m_depth];
  endfunction

  function automatic result_t execute_instr(input logic [7:0] op, input logic [7:0] b1,
                                            input logic [7:0] b2);
    result_t     res;
    logic [15:0] branch_pc;
    logic [31:0] lhs;
    logic [31:0] rhs;
    res = '0;
    res.error = ERR_NONE;
    if (m_halted) begin
      res.next_pc = m_pc;
      res.halted = 1'b1;
      return res;
    end
    branch_pc = m_pc + {b1, b2};
    res.next_pc = m_pc + 16'd1;
    case (op)
      OP_ICONST_M1, OP_ICONST_0, OP_ICONST_1, OP_ICONST_2, OP_ICONST_3, OP_ICONST_4,
      OP_ICONST_5:
        if (!stack_push({24'd0, op} - 32'd3)) res.error = ERR_OVER;
      OP_BIPUSH: begin
        if (!stack_push({{24{b1[7]}}, b1})) res.error = ERR_OVER;
        res.next_pc = m_pc + 16'd2;
      end
      OP_ILOAD_0, OP_ILOAD_1, OP_ILOAD_2:
        if (!stack_push(m_locals[op - OP_ILOAD_0])) res.error = ERR_OVER;
      OP_ALOAD_0:
        if (!stack_push(m_locals[0])) res.error = ERR_OVER;
      OP_ISTORE_0, OP_ISTORE_1, OP_ISTORE_2:
        if (m_depth < 1) res.error = ERR_UNDER;
        else m_locals[op - OP_ISTORE_0] = stack_pop();
      OP_ISHL:
        if (m_depth < 2) begin
          res.error = ERR_UNDER;
        end else begin
          rhs = stack_pop();
          lhs = stack_pop();
          void'(stack_push(lhs << (rhs[4:0] & SHIFT_MASK)));
        end
      OP_IINC: begin
        res.next_pc = m_pc + 16'd3;
        if (b1 >= LOCAL_COUNT) res.error = ERR_LOCAL;
        else m_locals[b1] = m_locals[b1] + {{24{b2[7]}}, b2};
      end
      OP_IFLT: begin
        res.next_pc = m_pc + 16'd3;
        if (m_depth < 1) begin
          res.error = ERR_UNDER;
        end else begin
          rhs = stack_pop();
          if (rhs[31]) res.next_pc = branch_pc;
        end
      end
      OP_IF_ICMPGE: begin
        res.next_pc = m_pc + 16'd3;
        if (m_depth < 2) begin
          res.error = ERR_UNDER;
        end else begin
          rhs = stack_pop();
          lhs = stack_pop();
          if ($signed(lhs) >= $signed(rhs)) res.next_pc = branch_pc;
        end
      end
      OP_GOTO: res.next_pc = branch_pc;
      OP_RETURN: begin
        m_halted = 1'b1;
        res.next_pc = m_pc;
      end
      OP_INVOKESPECIAL: res.next_pc = m_pc + 16'd3;
      OP_INVOKESTATIC: begin
        res.next_pc = m_pc + 16'd3;
        if (m_depth < 1) begin
          res.error = ERR_UNDER;
        end else begin
          rhs = stack_pop();
          res.led_value = rhs[7:0];
          res.led_valid = 1'b1;
        end
      end
      default: ;
    endcase
    m_pc = res.next_pc;
    res.halted = m_halted;
    return res;
  endfunction

  function automatic logic [7:0] random_push_op();
    case ($urandom_range(0, 3))
      0: return OP_ICONST_M1 + 8'($urandom_range(0, 6));
      1: return OP_BIPUSH;
      2: return OP_ILOAD_0 + 8'($urandom_range(0, 2));
      default: return OP_ALOAD_0;
    endcase
  endfunction

  function automatic logic [7:0] random_pop_op();
    case ($urandom_range(0, 4))
      0: return OP_ISTORE_0 + 8'($urandom_range(0, 2));
      1: return OP_ISHL;
      2: return OP_IFLT;
      3: return OP_IF_ICMPGE;
      default: return OP_INVOKESTATIC;
    endcase
  endfunction

  // Everything but RETURN, which would end the program early.
  function automatic logic [7:0] random_opcode();
    logic [7:0] code;
    case ($urandom_range(0, 11))
      0, 1, 2, 3: code = random_push_op();
      4, 5, 6: code = random_pop_op();
      7: code = OP_NOP;
      8: code = OP_IINC;
      9: code = OP_GOTO;
      10: code = OP_INVOKESPECIAL;
      default: begin
        code = 8'($urandom_range(0, 255));
        if (code == OP_RETURN) code = OP_NOP;
      end
    endcase
    return code;
  endfunction

  task automatic issue_instr(input logic [7:0] op, input logic [7:0] b1,
                             input logic [7:0] b2);
    int gap;
    gap = in_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    first_byte_i <= b1;
    second_byte_i <= b2;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predicted_results.push_back(execute_instr(op, b1, b2));
  endtask

  task automatic set_idle_mode();
    in_idle = ($urandom_range(0, 3) != 0);
    out_idle = ($urandom_range(0, 3) != 0);
  endtask

  task automatic test_empty_stack();
    issue_instr(OP_INVOKESTATIC, 8'h00, 8'h00);
    issue_instr(OP_IFLT, 8'hff, 8'hff);
    issue_instr(OP_IF_ICMPGE, 8'h00, 8'h10);
    issue_instr(OP_ISTORE_0, 8'h00, 8'h00);
    issue_instr(OP_ISHL, 8'h00, 8'h00);
    issue_instr(8'hff, 8'hff, 8'hff);
    issue_instr(OP_NOP, 8'h00, 8'h00);
  endtask

  task automatic test_each_opcode();
    issue_instr(OP_ICONST_M1, 8'h00, 8'h00);
    issue_instr(OP_ICONST_5, 8'h00, 8'h00);
    issue_instr(OP_IF_ICMPGE, 8'h00, 8'h10);
    issue_instr(OP_ICONST_5, 8'h00, 8'h00);
    issue_instr(OP_ICONST_M1, 8'h00, 8'h00);
    issue_instr(OP_IF_ICMPGE, 8'h80, 8'h00);
    issue_instr(OP_BIPUSH, 8'h80, 8'h00);
    issue_instr(OP_IFLT, 8'h80, 8'h00);
    issue_instr(OP_BIPUSH, 8'h7f, 8'hff);
    issue_instr(OP_ICONST_4, 8'h00, 8'h00);
    issue_instr(OP_ISHL, 8'h00, 8'h00);
    issue_instr(OP_ISTORE_2, 8'h00, 8'h00);
    issue_instr(OP_IINC, 8'h02, 8'hff);
    issue_instr(OP_IINC, 8'hff, 8'h01);
    issue_instr(OP_IINC, 8'h0f, 8'h7f);
    issue_instr(OP_ILOAD_2, 8'h00, 8'h00);
    issue_instr(OP_ILOAD_1, 8'h00, 8'h00);
    issue_instr(OP_ILOAD_0, 8'h00, 8'h00);
    issue_instr(OP_ALOAD_0, 8'h00, 8'h00);
    issue_instr(OP_ISTORE_1, 8'h00, 8'h00);
    issue_instr(OP_INVOKESTATIC, 8'h00, 8'h00);
    issue_instr(OP_INVOKESPECIAL, 8'hff, 8'hff);
    issue_instr(OP_GOTO, 8'hff, 8'hfd);
  endtask

  // Fill the stack to the top and sometimes past it, then drain it to the bottom and sometimes past it.
  task automatic test_stack_limits(input int reps);
    int extra;
    for (int r = 0; r < reps; r++) begin
      set_idle_mode();
      extra = $urandom_range(0, 2);
      while (m_depth < STACK_DEPTH)
        issue_instr(random_push_op(), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      repeat (extra)
        issue_instr(random_push_op(), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      extra = $urandom_range(0, 2);
      while (m_depth > 0)
        issue_instr(random_pop_op(), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      repeat (extra)
        issue_instr(random_pop_op(), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_program(input int count);
    logic [7:0] op;
    logic [7:0] b1;
    logic [7:0] b2;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) set_idle_mode();
      op = random_opcode();
      b1 = 8'($urandom_range(0, 255));
      b2 = 8'($urandom_range(0, 255));
      // keep most increments on a real local
      if (op == OP_IINC && $urandom_range(0, 7) != 0)
        b1 = 8'($urandom_range(0, LOCAL_COUNT - 1));
      issue_instr(op, b1, b2);
    end
  endtask

  task automatic test_return_halts();
    issue_instr(OP_RETURN, 8'h00, 8'h00);
    issue_instr(OP_ICONST_1, 8'h00, 8'h00);
    issue_instr(OP_GOTO, 8'h12, 8'h34);
    issue_instr(OP_INVOKESTATIC, 8'h00, 8'h00);
    issue_instr(OP_RETURN, 8'hff, 8'hff);
  endtask

  task automatic report_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual next_pc %0h", $time,
                   next_pc_o);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          report_field("next_pc", want.next_pc, next_pc_o);
          report_field("led_valid", want.led_valid, led_valid_o);
          report_field("led_value", want.led_value, led_value_o);
          report_field("halted", want.halted, halted_o);
          report_field("error", want.error, error_o);
        end
        out_wait = out_idle ? $urandom_range(0, 10) : 0;
      end
      if (out_wait > 0) begin
        out_stall_i <= 1'b1;
        out_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < LOCAL_COUNT; i++) m_locals[i] = '0;
    for (int i = 0; i < STACK_DEPTH; i++) m_stack[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_stack();
    test_each_opcode();
    test_stack_limits(20);
    test_random_program(1000);
    test_return_halts();
    in_valid_i <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
